// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked concurrent assertions with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPQB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sprite batcher assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SPQB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sprite batcher assertion failed");

`endif

// ===== hw/rtl/spqb_pkg.sv =====
// ----------------------------------------------------------------------------
// Sprite quad batcher package
// Shared payload types, status codes, register indexes and defaults.
// ----------------------------------------------------------------------------
package spqb_pkg;

	localparam int TEXTURE_SLOTS_DEF = 64;
	localparam int MAX_QUADS_DEF     = 256;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_START = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_STEP  = 1'b1;

	localparam logic signed [31:0] DEPTH_START_RST = 32'sh0001_0000;
	localparam logic signed [31:0] DEPTH_STEP_RST  = -32'sd1;

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	typedef enum logic [1:0] {
		ST_VERTEX     = 2'd0,
		ST_BATCH_FULL = 2'd1,
		ST_TABLE_FULL = 2'd2,
		ST_FLUSH      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		C_TL = 2'd0,
		C_TR = 2'd1,
		C_BR = 2'd2,
		C_BL = 2'd3
	} corner_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_DISPATCH
	} ctrl_state_t;

	typedef struct packed {
		logic               operation;
		logic [63:0]        texture_handle;
		logic signed [31:0] rect_left;
		logic signed [31:0] rect_top;
		logic signed [31:0] rect_width;
		logic signed [31:0] rect_height;
		logic signed [31:0] uv_left;
		logic signed [31:0] uv_top;
		logic signed [31:0] uv_width;
		logic signed [31:0] uv_height;
		logic [31:0]        color_rgba;
	} sprite_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] depth;
		logic signed [31:0] tex_u;
		logic signed [31:0] tex_v;
		logic [5:0]         slot_index;
		logic [31:0]        vertex_color;
		logic [8:0]         quad_count;
		logic [6:0]         slot_count;
		logic               last;
	} result_t;

	// Job handed from the batch controller to the vertex emitter.
	typedef struct packed {
		logic               load;
		status_t            status;
		logic [5:0]         slot;
		logic signed [31:0] depth;
		logic [8:0]         quad_count;
		logic [6:0]         slot_count;
	} emit_job_t;

endpackage

// ===== hw/rtl/spqb_slot_cell.sv =====
// ----------------------------------------------------------------------------
// Slot cell
// Holds one texture handle and passes the lookup token to its neighbor.
// ----------------------------------------------------------------------------
module spqb_slot_cell #(
	parameter int IDX    = 0,
	parameter int SLOT_W = 6,
	parameter int CNT_W  = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [63:0]       probe,
	input  logic [CNT_W-1:0]  used,
	input  logic              append,
	input  logic              hit_in,
	input  logic [SLOT_W-1:0] slot_in,
	output logic              hit_out,
	output logic [SLOT_W-1:0] slot_out
);

	logic [63:0]       entry_q;
	logic              hit_q;
	logic [SLOT_W-1:0] slot_q;
	logic              occupied;
	logic              match;

	// The entry counts only while it lies below the fill count.
	assign occupied = CNT_W'(IDX) < used;
	assign match    = occupied && (entry_q == probe);

	always_ff @(posedge clk) begin
		if (append && (used == CNT_W'(IDX))) begin
			entry_q <= probe;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else begin
			hit_q <= hit_in | match;
		end
	end

	always_ff @(posedge clk) begin
		slot_q <= hit_in ? slot_in : SLOT_W'(IDX);
	end

	assign hit_out  = hit_q;
	assign slot_out = slot_q;

endmodule

// ===== hw/rtl/spqb_slot_chain.sv =====
// ----------------------------------------------------------------------------
// Slot chain
// Row of slot cells; the lookup token ripples one cell per clock.
// ----------------------------------------------------------------------------
module spqb_slot_chain #(
	parameter int SLOTS = spqb_pkg::TEXTURE_SLOTS_DEF,
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
	localparam int CNT_W  = $clog2(SLOTS + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [63:0]       probe,
	input  logic [CNT_W-1:0]  used,
	input  logic              append,
	output logic              hit,
	output logic [SLOT_W-1:0] slot
);

	logic              hit_w  [0:SLOTS];
	logic [SLOT_W-1:0] slot_w [0:SLOTS];

	assign hit_w[0]  = 1'b0;
	assign slot_w[0] = '0;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		spqb_slot_cell #(
			.IDX    (i),
			.SLOT_W (SLOT_W),
			.CNT_W  (CNT_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.probe    (probe),
			.used     (used),
			.append   (append),
			.hit_in   (hit_w[i]),
			.slot_in  (slot_w[i]),
			.hit_out  (hit_w[i+1]),
			.slot_out (slot_w[i+1])
		);
	end

	assign hit  = hit_w[SLOTS];
	assign slot = slot_w[SLOTS];

endmodule

// ===== hw/rtl/spqb_quad_emit.sv =====
// ----------------------------------------------------------------------------
// Quad emitter
// Output register that expands one job into four corner beats or one report.
// ----------------------------------------------------------------------------
module spqb_quad_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  spqb_pkg::emit_job_t job,
	input  spqb_pkg::sprite_t   item,
	output logic                job_ready,
	output logic                result_valid,
	input  logic                result_ready,
	output spqb_pkg::result_t   result
);

	logic                busy_q;
	spqb_pkg::corner_t   corner_q;
	spqb_pkg::status_t   status_q;
	logic signed [31:0]  left_q, right_q, top_q, bottom_q;
	logic signed [31:0]  u_left_q, u_right_q, v_top_q, v_bottom_q;
	logic signed [31:0]  depth_q;
	logic [5:0]          slot_q;
	logic [31:0]         color_q;
	logic [8:0]          quad_count_q;
	logic [6:0]          slot_count_q;
	logic                single;
	logic                final_beat;
	logic                use_left, use_top;

	assign single     = status_q != spqb_pkg::ST_VERTEX;
	assign final_beat = single || (corner_q == spqb_pkg::C_BL);
	assign job_ready  = !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			corner_q <= spqb_pkg::C_TL;
		end else if (job.load) begin
			busy_q   <= 1'b1;
			corner_q <= spqb_pkg::C_TL;
		end else if (busy_q && result_ready) begin
			if (final_beat) begin
				busy_q <= 1'b0;
			end
			case (corner_q)
				spqb_pkg::C_TL: corner_q <= spqb_pkg::C_TR;
				spqb_pkg::C_TR: corner_q <= spqb_pkg::C_BR;
				spqb_pkg::C_BR: corner_q <= spqb_pkg::C_BL;
				default:        corner_q <= spqb_pkg::C_TL;
			endcase
		end
	end

	// Edges are summed once at load; sums wrap modulo 2^32.
	always_ff @(posedge clk) begin
		if (job.load) begin
			status_q     <= job.status;
			left_q       <= item.rect_left;
			top_q        <= item.rect_top;
			right_q      <= item.rect_left + item.rect_width;
			bottom_q     <= item.rect_top + item.rect_height;
			u_left_q     <= item.uv_left;
			v_top_q      <= item.uv_top;
			u_right_q    <= item.uv_left + item.uv_width;
			v_bottom_q   <= item.uv_top + item.uv_height;
			depth_q      <= job.depth;
			slot_q       <= job.slot;
			color_q      <= item.color_rgba;
			quad_count_q <= job.quad_count;
			slot_count_q <= job.slot_count;
		end
	end

	assign use_left = (corner_q == spqb_pkg::C_TL) || (corner_q == spqb_pkg::C_BL);
	assign use_top  = (corner_q == spqb_pkg::C_TL) || (corner_q == spqb_pkg::C_TR);

	always_comb begin
		result_valid      = busy_q;
		result            = '0;
		result.status     = status_q;
		result.last       = final_beat;
		result.quad_count = quad_count_q;
		result.slot_count = slot_count_q;
		if (!single) begin
			result.pos_x        = use_left ? left_q : right_q;
			result.pos_y        = use_top ? top_q : bottom_q;
			result.tex_u        = use_left ? u_left_q : u_right_q;
			result.tex_v        = use_top ? v_top_q : v_bottom_q;
			result.depth        = depth_q;
			result.slot_index   = slot_q;
			result.vertex_color = color_q;
		end
	end

endmodule

// ===== hw/rtl/sprite_quad_batcher_core.sv =====
// Add beat: accepted in IDLE, then held through SEARCH and through DISPATCH, which
// waits for the emitter; the first vertex shows in the cycle after the handover.
// An add, like a table-full error, spends its search on the token walk down the
// slot chain; flush and batch-full beats go from IDLE straight to DISPATCH.
// Emission overlaps the next search. Reset clears the counts, loads the default
// registers and the running depth; slot entries are not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
// Sprite quad batcher core
// Looks up or appends sprite textures in a slot chain and emits quad corners.
// ----------------------------------------------------------------------------
module sprite_quad_batcher_core #(
	parameter int TEXTURE_SLOTS = spqb_pkg::TEXTURE_SLOTS_DEF,
	parameter int MAX_QUADS     = spqb_pkg::MAX_QUADS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           sprite_valid,
	output logic                           sprite_ready,
	input  spqb_pkg::sprite_t              sprite,
	output logic                           result_valid,
	input  logic                           result_ready,
	output spqb_pkg::result_t              result,
	input  logic                           wr_en,
	input  logic [spqb_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [31:0]                    wr_data
);

	localparam int SLOT_W     = (TEXTURE_SLOTS > 1) ? $clog2(TEXTURE_SLOTS) : 1;
	localparam int CNT_W      = $clog2(TEXTURE_SLOTS + 1);
	localparam int QCNT_W     = $clog2(MAX_QUADS + 1);
	localparam int SLOT_EXT_W = (SLOT_W > 6) ? SLOT_W : 6;
	localparam int CNT_EXT_W  = (CNT_W > 7) ? CNT_W : 7;
	localparam int QCNT_EXT_W = (QCNT_W > 9) ? QCNT_W : 9;

	spqb_pkg::ctrl_state_t state_q, state_d;
	spqb_pkg::sprite_t     item_q;
	spqb_pkg::emit_job_t   job;
	spqb_pkg::status_t     dec_status;

	logic [CNT_W-1:0]      search_cnt_q;
	logic [CNT_W-1:0]      slots_used_q;
	logic [QCNT_W-1:0]     quads_used_q;
	logic signed [31:0]    running_depth_q;
	logic signed [31:0]    depth_start_q;
	logic signed [31:0]    depth_step_q;

	logic                  chain_hit;
	logic [SLOT_W-1:0]     chain_slot;
	logic [SLOT_W-1:0]     quad_slot;
	logic [SLOT_EXT_W-1:0] slot_ext;
	logic [CNT_EXT_W-1:0]  slot_cnt_ext;
	logic [QCNT_EXT_W-1:0] quad_cnt_ext;
	logic                  job_ready;
	logic                  batch_full;
	logic                  table_full;
	logic                  is_flush;
	logic                  search_done;
	logic                  fire;
	logic                  append;

	// The chain sees the held handle and the current fill count. A token that
	// starts at cell zero is registered in each cell on its way to the far end,
	// and both inputs stay put for the whole search, so stale tokens drain away.
	spqb_slot_chain #(
		.SLOTS (TEXTURE_SLOTS)
	) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.probe  (item_q.texture_handle),
		.used   (slots_used_q),
		.append (append),
		.hit    (chain_hit),
		.slot   (chain_slot)
	);

	spqb_quad_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.job          (job),
		.item         (item_q),
		.job_ready    (job_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// Decision for the held beat. A flush is checked first, then the batch
	// limit, and the table limit only when the handle was not found.
	assign batch_full  = quads_used_q >= QCNT_W'(MAX_QUADS);
	assign table_full  = slots_used_q >= CNT_W'(TEXTURE_SLOTS);
	assign is_flush    = item_q.operation == spqb_pkg::OP_FLUSH;
	assign search_done = search_cnt_q == CNT_W'(TEXTURE_SLOTS);

	always_comb begin
		if (is_flush) begin
			dec_status = spqb_pkg::ST_FLUSH;
		end else if (batch_full) begin
			dec_status = spqb_pkg::ST_BATCH_FULL;
		end else if (!chain_hit && table_full) begin
			dec_status = spqb_pkg::ST_TABLE_FULL;
		end else begin
			dec_status = spqb_pkg::ST_VERTEX;
		end
	end

	// A new handle takes the slot at the fill count, which is below the
	// table size whenever a vertex job goes out without a hit.
	assign quad_slot    = chain_hit ? chain_slot : slots_used_q[SLOT_W-1:0];
	assign slot_ext     = SLOT_EXT_W'(quad_slot);
	assign slot_cnt_ext = CNT_EXT_W'(slots_used_q);
	assign quad_cnt_ext = QCNT_EXT_W'(quads_used_q);

	assign fire   = (state_q == spqb_pkg::S_DISPATCH) && job_ready;
	assign append = fire && (dec_status == spqb_pkg::ST_VERTEX) && !chain_hit;

	// Next state. Flush beats and beats that meet a full batch need no search.
	always_comb begin
		state_d = state_q;
		case (state_q)
			spqb_pkg::S_IDLE: begin
				if (sprite_valid) begin
					if ((sprite.operation == spqb_pkg::OP_FLUSH) || batch_full) begin
						state_d = spqb_pkg::S_DISPATCH;
					end else begin
						state_d = spqb_pkg::S_SEARCH;
					end
				end
			end
			spqb_pkg::S_SEARCH: begin
				if (search_done) begin
					state_d = spqb_pkg::S_DISPATCH;
				end
			end
			spqb_pkg::S_DISPATCH: begin
				if (job_ready) begin
					state_d = spqb_pkg::S_IDLE;
				end
			end
			default: state_d = spqb_pkg::S_IDLE;
		endcase
	end

	// Outputs of the controller: the input handshake and the emitter job.
	always_comb begin
		sprite_ready   = state_q == spqb_pkg::S_IDLE;
		job            = '0;
		job.load       = fire;
		job.status     = dec_status;
		job.depth      = running_depth_q;
		if (dec_status == spqb_pkg::ST_VERTEX) begin
			job.slot = slot_ext[5:0];
		end
		if (dec_status == spqb_pkg::ST_FLUSH) begin
			job.quad_count = quad_cnt_ext[8:0];
			job.slot_count = slot_cnt_ext[6:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= spqb_pkg::S_IDLE;
			search_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == spqb_pkg::S_SEARCH) begin
				search_cnt_q <= search_cnt_q + CNT_W'(1);
			end else begin
				search_cnt_q <= '0;
			end
		end
	end

	// The accepted beat is held for the search and for the emitter's load.
	always_ff @(posedge clk) begin
		if (sprite_valid && sprite_ready) begin
			item_q <= sprite;
		end
	end

	// Batch state changes only when a job leaves for the emitter. A flush
	// reloads the running depth even when the batch is already empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_used_q    <= '0;
			quads_used_q    <= '0;
			running_depth_q <= spqb_pkg::DEPTH_START_RST;
		end else if (fire) begin
			if (dec_status == spqb_pkg::ST_FLUSH) begin
				slots_used_q    <= '0;
				quads_used_q    <= '0;
				running_depth_q <= depth_start_q;
			end else if (dec_status == spqb_pkg::ST_VERTEX) begin
				quads_used_q    <= quads_used_q + QCNT_W'(1);
				running_depth_q <= running_depth_q + depth_step_q;
				if (append) begin
					slots_used_q <= slots_used_q + CNT_W'(1);
				end
			end
		end
	end

	// Configuration writes take effect at the next flush for the start depth
	// and at the next accepted quad for the step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_start_q <= spqb_pkg::DEPTH_START_RST;
			depth_step_q  <= spqb_pkg::DEPTH_STEP_RST;
		end else if (wr_en) begin
			case (wr_index)
				spqb_pkg::CFG_DEPTH_START: depth_start_q <= wr_data;
				spqb_pkg::CFG_DEPTH_STEP:  depth_step_q  <= wr_data;
				default: ;
			endcase
		end
	end

endmodule

// ===== hw/rtl/spqb_checker.sv =====
// ----------------------------------------------------------------------------
// Sprite quad batcher checker
// Port-level assertions on beat ordering, bound to the core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spqb_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           sprite_valid,
	input logic                           sprite_ready,
	input spqb_pkg::sprite_t              sprite,
	input logic                           result_valid,
	input logic                           result_ready,
	input spqb_pkg::result_t              result,
	input logic                           wr_en,
	input logic [spqb_pkg::CFG_IDX_W-1:0] wr_index,
	input logic [31:0]                    wr_data
);

	logic vtx_beat_mid;

	assign vtx_beat_mid = result_valid && result_ready && !result.last &&
		(result.status == spqb_pkg::ST_VERTEX);

	// The core works on one sprite beat at a time.
	`SPQB_ASSERT_NEXT(a_accept_drops_ready, clk, arst_n, sprite_valid && sprite_ready, !sprite_ready)

	// Corners of one quad follow without a gap and share one depth.
	`SPQB_ASSERT_NEXT(a_quad_continues, clk, arst_n, vtx_beat_mid, result_valid && (result.status == spqb_pkg::ST_VERTEX) && (result.depth == $past(result.depth)))

	// A stalled result beat holds.
	`SPQB_ASSERT_NEXT(a_stall_holds, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result))

	// Vertices never carry batch counts.
	`SPQB_ASSERT_NOW(a_vertex_no_counts, clk, arst_n, result_valid && (result.status == spqb_pkg::ST_VERTEX), (result.quad_count == 9'd0) && (result.slot_count == 7'd0))

endmodule

bind sprite_quad_batcher_core spqb_checker u_spqb_checker (.*);

// ===== test/tb_sprite_quad_batcher_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sprite quad batcher core testbench
// Runs a short table of hand-picked sprites, then fills the texture table
// and the batch to the brim, then several phases of random sprites and
// flushes under different depth settings. Every result beat is compared
// with a software copy of the batcher that is kept in step with the inputs.
// ----------------------------------------------------------------------------
module tb_sprite_quad_batcher_core;

	localparam int TEXTURE_SLOTS = spqb_pkg::TEXTURE_SLOTS_DEF;
	localparam int MAX_QUADS     = spqb_pkg::MAX_QUADS_DEF;

	// After the last expected beat we keep watching for stray beats.
	localparam int DRAIN_CYCLES = 2 * (TEXTURE_SLOTS + 3);

	// Generous timeout for the whole run, in nanoseconds.
	localparam int LIMIT_NS = 5_000_000;

	localparam int RANDOM_PHASES    = 4;
	localparam int RANDOM_PER_PHASE = 5;
	localparam int POOL_SIZE        = 6;

	// Receiver hold-off: at these beat counts the receiver stops taking
	// beats for a long stretch, so the core backs up and stalls its input.
	localparam int HOLD_CYCLES  = 300;
	localparam int HOLD_FIRST   = 600;
	localparam int HOLD_SECOND  = 900;

	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
	localparam logic [63:0] H_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct {
		spqb_pkg::sprite_t item;
		bit                typed;
		spqb_pkg::result_t want;
	} directed_row_t;

	logic                           clk;
	logic                           arst_n;
	logic                           sprite_valid;
	logic                           sprite_ready;
	spqb_pkg::sprite_t              sprite;
	logic                           result_valid;
	logic                           result_ready;
	spqb_pkg::result_t              result;
	logic                           wr_en;
	logic [spqb_pkg::CFG_IDX_W-1:0] wr_index;
	logic [31:0]                    wr_data;

	// Software copy of the batch: registers, handle table and counters.
	// The table is searched from slot 0 upward and the first match wins, just
	// as the lowest matching cell wins in the slot chain of the core.
	logic signed [31:0] depth_start_reg;
	logic signed [31:0] depth_step_reg;
	logic signed [31:0] running_depth;
	logic [63:0]        handle_table [TEXTURE_SLOTS];
	int                 slots_used;
	int                 quads_used;

	spqb_pkg::result_t corner_results [4];
	spqb_pkg::result_t awaited_results [$];
	directed_row_t     directed_rows [$];

	int mismatches;
	int results_seen;
	bit steady;

	sprite_quad_batcher_core #(
		.TEXTURE_SLOTS(TEXTURE_SLOTS),
		.MAX_QUADS    (MAX_QUADS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.sprite_valid(sprite_valid),
		.sprite_ready(sprite_ready),
		.sprite      (sprite),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(LIMIT_NS);
		$display("TB_ERROR");
		$finish;
	end

	// Works out the beats that one sprite item causes and updates the batch.
	// The beats land in corner_results; the return value says how many.
	function automatic int batch_sprite(input spqb_pkg::sprite_t s);
		spqb_pkg::result_t base;
		int      slot;
		bit      hit;
		logic signed [31:0] x_right, y_bottom, u_right, v_bottom;
		base = '0;
		base.last = 1'b1;
		slot = 0;
		hit = 1'b0;
		if (s.operation == spqb_pkg::OP_FLUSH) begin
			base.status = spqb_pkg::ST_FLUSH;
			base.quad_count = quads_used[8:0];
			base.slot_count = slots_used[6:0];
			corner_results[0] = base;
			slots_used = 0;
			quads_used = 0;
			running_depth = depth_start_reg;
			return 1;
		end
		// Short of a flush, a full batch wins over everything else, even an unknown handle.
		if (quads_used >= MAX_QUADS) begin
			base.status = spqb_pkg::ST_BATCH_FULL;
			corner_results[0] = base;
			return 1;
		end
		for (int i = 0; i < slots_used; i++) begin
			if (!hit && handle_table[i] == s.texture_handle) begin
				slot = i;
				hit = 1'b1;
			end
		end
		if (!hit) begin
			if (slots_used >= TEXTURE_SLOTS) begin
				base.status = spqb_pkg::ST_TABLE_FULL;
				corner_results[0] = base;
				return 1;
			end
			slot = slots_used;
			handle_table[slot] = s.texture_handle;
			slots_used++;
		end
		// All sums wrap at 32 bits, just as the core's adders do.
		x_right  = s.rect_left + s.rect_width;
		y_bottom = s.rect_top + s.rect_height;
		u_right  = s.uv_left + s.uv_width;
		v_bottom = s.uv_top + s.uv_height;
		base.status = spqb_pkg::ST_VERTEX;
		base.depth = running_depth;
		base.slot_index = slot[5:0];
		base.vertex_color = s.color_rgba;
		base.last = 1'b0;
		// Corners go out top-left, top-right, bottom-right, bottom-left.
		corner_results[0] = base;
		corner_results[0].pos_x = s.rect_left;
		corner_results[0].pos_y = s.rect_top;
		corner_results[0].tex_u = s.uv_left;
		corner_results[0].tex_v = s.uv_top;
		corner_results[1] = base;
		corner_results[1].pos_x = x_right;
		corner_results[1].pos_y = s.rect_top;
		corner_results[1].tex_u = u_right;
		corner_results[1].tex_v = s.uv_top;
		corner_results[2] = base;
		corner_results[2].pos_x = x_right;
		corner_results[2].pos_y = y_bottom;
		corner_results[2].tex_u = u_right;
		corner_results[2].tex_v = v_bottom;
		corner_results[3] = base;
		corner_results[3].pos_x = s.rect_left;
		corner_results[3].pos_y = y_bottom;
		corner_results[3].tex_u = s.uv_left;
		corner_results[3].tex_v = v_bottom;
		corner_results[3].last = 1'b1;
		quads_used++;
		running_depth = running_depth + depth_step_reg;
		return 4;
	endfunction

	function automatic spqb_pkg::sprite_t make_sprite(input logic op,
			input logic [63:0] handle,
			input logic signed [31:0] left, input logic signed [31:0] top,
			input logic signed [31:0] width, input logic signed [31:0] height,
			input logic signed [31:0] u_left, input logic signed [31:0] v_top,
			input logic signed [31:0] u_width, input logic signed [31:0] v_height,
			input logic [31:0] color);
		spqb_pkg::sprite_t s;
		s.operation      = op;
		s.texture_handle = handle;
		s.rect_left      = left;
		s.rect_top       = top;
		s.rect_width     = width;
		s.rect_height    = height;
		s.uv_left        = u_left;
		s.uv_top         = v_top;
		s.uv_width       = u_width;
		s.uv_height      = v_height;
		s.color_rgba     = color;
		return s;
	endfunction

	function automatic spqb_pkg::sprite_t random_sprite(input logic op,
			input logic [63:0] handle);
		return make_sprite(op, handle, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom, $urandom);
	endfunction

	// A flush report or an error carries nothing but its status, the counts
	// on a flush, and last.
	function automatic spqb_pkg::result_t lone_beat(input spqb_pkg::status_t status,
			input int quads, input int slots);
		spqb_pkg::result_t r;
		r = '0;
		r.status = status;
		r.quad_count = quads[8:0];
		r.slot_count = slots[6:0];
		r.last = 1'b1;
		return r;
	endfunction

	function automatic void add_row(input spqb_pkg::sprite_t item, input bit typed,
			input spqb_pkg::result_t want);
		directed_row_t row;
		row.item = item;
		row.typed = typed;
		row.want = want;
		directed_rows.push_back(row);
	endfunction

	// Presents one sprite beat and holds it until the core takes it. The
	// sender may idle first, but not in a steady phase; valid is only ever
	// changed at a falling edge, and only once per edge. The expected beats
	// are queued at the edge that accepts the sprite.
	task automatic offer(input spqb_pkg::sprite_t s, input bit typed,
			input spqb_pkg::result_t want);
		int n;
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 20) begin
			sprite_valid <= 1'b0;
			@(negedge clk);
		end
		sprite <= s;
		sprite_valid <= 1'b1;
		@(posedge clk);
		while (!sprite_ready)
			@(posedge clk);
		n = batch_sprite(s);
		if (typed)
			awaited_results.push_back(want);
		else
			for (int k = 0; k < n; k++)
				awaited_results.push_back(corner_results[k]);
	endtask

	// Drops valid right after the last accepted beat, then waits until the
	// core has handed back everything that is owed.
	task automatic pause_until_drained();
		@(negedge clk);
		sprite_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	// Writes the start depth register, then the step depth register. The running
	// depth is not touched: it only reloads from depth_start on a flush.
	task automatic load_depth_regs(input logic signed [31:0] start,
			input logic signed [31:0] step);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= spqb_pkg::CFG_DEPTH_START;
		wr_data <= start;
		@(negedge clk);
		wr_index <= spqb_pkg::CFG_DEPTH_STEP;
		wr_data <= step;
		@(negedge clk);
		wr_en <= 1'b0;
		depth_start_reg = start;
		depth_step_reg = step;
	endtask

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	// Result checker: every accepted beat is matched against the oldest
	// expectation, field by field.
	always @(posedge clk) begin : beat_check
		spqb_pkg::result_t want;
		if (arst_n && result_valid && result_ready) begin
			results_seen++;
			if (awaited_results.size() == 0) begin
				$error("result beat with nothing expected, status 0x%0h", result.status);
				mismatches++;
			end else begin
				want = awaited_results.pop_front();
				compare_field("status", want.status, result.status);
				compare_field("pos_x", want.pos_x, result.pos_x);
				compare_field("pos_y", want.pos_y, result.pos_y);
				compare_field("depth", want.depth, result.depth);
				compare_field("tex_u", want.tex_u, result.tex_u);
				compare_field("tex_v", want.tex_v, result.tex_v);
				compare_field("slot_index", want.slot_index, result.slot_index);
				compare_field("vertex_color", want.vertex_color, result.vertex_color);
				compare_field("quad_count", want.quad_count, result.quad_count);
				compare_field("slot_count", want.slot_count, result.slot_count);
				compare_field("last", want.last, result.last);
			end
		end
	end

	// Receiver: ready about 80% of the time and always during a steady phase,
	// but twice held low for a long stretch so that the core backs up.
	initial begin : receiver
		int hold_left;
		int holds_done;
		hold_left = 0;
		holds_done = 0;
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left == 0 &&
					((holds_done == 0 && results_seen >= HOLD_FIRST) ||
					(holds_done == 1 && results_seen >= HOLD_SECOND))) begin
				hold_left = HOLD_CYCLES;
				holds_done++;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (steady) begin
				result_ready <= 1'b1;
			end else begin
				result_ready <= ($urandom_range(0, 99) >= 20);
			end
		end
	end

	initial begin : stimulus
		logic [63:0]        fill_handles [TEXTURE_SLOTS];
		logic [63:0]        handle_pool [POOL_SIZE];
		logic [63:0]        stranger;
		logic [63:0]        handle;
		logic               op;
		logic signed [31:0] phase_start [RANDOM_PHASES];
		logic signed [31:0] phase_step [RANDOM_PHASES];

		arst_n = 1'b0;
		sprite_valid = 1'b0;
		sprite = '0;
		wr_en = 1'b0;
		wr_index = spqb_pkg::CFG_DEPTH_START;
		wr_data = '0;
		steady = 1'b0;
		mismatches = 0;
		results_seen = 0;
		depth_start_reg = spqb_pkg::DEPTH_START_RST;
		depth_step_reg = spqb_pkg::DEPTH_STEP_RST;
		running_depth = spqb_pkg::DEPTH_START_RST;
		slots_used = 0;
		quads_used = 0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table, run with the reset register values. Only flush
		// reports have their beat typed in; the rest go through the model.
		// A flush straight out of reset reports an empty batch.
		add_row(make_sprite(spqb_pkg::OP_FLUSH, '0, 0, 0, 0, 0, 0, 0, 0, 0, '0),
			1'b1, lone_beat(spqb_pkg::ST_FLUSH, 0, 0));
		// All-zero sprite on the all-zero handle takes slot 0.
		add_row(make_sprite(spqb_pkg::OP_ADD, '0, 0, 0, 0, 0, 0, 0, 0, 0, '0),
			1'b0, '0);
		// Largest positive coordinates: every right/bottom sum wraps.
		add_row(make_sprite(spqb_pkg::OP_ADD, H_ONES, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
			Q_MAX, Q_MAX, Q_MAX, Q_MAX, 32'hFFFF_FFFF), 1'b0, '0);
		// Most negative coordinates, back on the handle of slot 0.
		add_row(make_sprite(spqb_pkg::OP_ADD, '0, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
			Q_MIN, Q_MIN, Q_MIN, Q_MIN, 32'h0000_0000), 1'b0, '0);
		// Sums that cross the sign boundary one step either way.
		add_row(make_sprite(spqb_pkg::OP_ADD, H_ONES, Q_MAX, Q_MIN, 32'sd1, -32'sd1,
			-32'sd1, 32'sd0, 32'sd1, -32'sd1, 32'h1234_5678), 1'b0, '0);
		// Same handle twice in a row.
		add_row(make_sprite(spqb_pkg::OP_ADD, H_ONES, -32'sh0001_0000,
			32'sh0002_8000, 32'sh0002_0000, 32'sh0000_8000, 32'sh0000_0000,
			32'sh0000_4000, 32'sh0001_0000, 32'sh0000_C000, 32'hFF00_FF00),
			1'b0, '0);
		add_row(make_sprite(spqb_pkg::OP_ADD, 64'h8000_0000_0000_0001,
			32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'sh5555_5555,
			32'shAAAA_AAAA, 32'sh5555_5555, 32'sh5555_5555, 32'shAAAA_AAAA,
			32'hA5A5_A5A5), 1'b0, '0);
		// Back to slot 0 after a new handle was added.
		add_row(make_sprite(spqb_pkg::OP_ADD, '0, 32'sh0010_0000, 32'sh0020_0000,
			-32'sd1, -32'sd1, 32'sh0000_1000, 32'sh0000_2000, -32'sh0000_1000,
			-32'sh0000_2000, 32'h0F0F_0F0F), 1'b0, '0);
		// Seven quads on three textures so far.
		add_row(make_sprite(spqb_pkg::OP_FLUSH, 64'h0123_4567_89AB_CDEF,
			1, 2, 3, 4, 5, 6, 7, 8, 32'hDEAD_BEEF),
			1'b1, lone_beat(spqb_pkg::ST_FLUSH, 7, 3));
		// Flush of an empty batch; the other fields are junk and are ignored.
		add_row(make_sprite(spqb_pkg::OP_FLUSH, H_ONES, Q_MIN, Q_MAX, Q_MIN, Q_MAX,
			-32'sd1, -32'sd1, -32'sd1, -32'sd1, 32'hFFFF_FFFF),
			1'b1, lone_beat(spqb_pkg::ST_FLUSH, 0, 0));
		// After the flush the table starts over at slot 0 and the depth reloads.
		add_row(make_sprite(spqb_pkg::OP_ADD, H_ONES, 32'sh0040_0000,
			32'sh0030_0000, 32'sh0008_0000, 32'sh0008_0000, 32'sh0000_0000,
			32'sh0000_0000, 32'sh0001_0000, 32'sh0001_0000, 32'h8040_2010),
			1'b0, '0);
		add_row(make_sprite(spqb_pkg::OP_ADD, 64'h0123_4567_89AB_CDEF,
			-32'sh0040_0000, -32'sh0030_0000, 32'sh0000_0001, 32'sh7FFF_0000,
			32'sh0000_8000, 32'sh0000_8000, -32'sh0000_8000, -32'sh0000_8000,
			32'h0102_0304), 1'b0, '0);

		foreach (directed_rows[r])
			offer(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);

		// Fill phase: the largest start depth and a step of one, so the
		// running depth wraps on the second quad. First the table gets all
		// of its textures, then one more texture hits the full table, then
		// the batch is topped up to its limit and refuses two more quads.
		pause_until_drained();
		load_depth_regs(Q_MAX, 32'sd1);
		offer(random_sprite(spqb_pkg::OP_FLUSH, {$urandom, $urandom}), 1'b0, '0);
		for (int i = 0; i < TEXTURE_SLOTS; i++) begin
			fill_handles[i] = {$urandom, $urandom};
			fill_handles[i][5:0] = i[5:0];
			offer(random_sprite(spqb_pkg::OP_ADD, fill_handles[i]), 1'b0, '0);
		end
		stranger = {$urandom, $urandom};
		offer(random_sprite(spqb_pkg::OP_ADD, stranger), 1'b0, '0);
		for (int i = 0; i < MAX_QUADS - TEXTURE_SLOTS; i++)
			offer(random_sprite(spqb_pkg::OP_ADD,
				fill_handles[$urandom_range(0, TEXTURE_SLOTS - 1)]), 1'b0, '0);
		offer(random_sprite(spqb_pkg::OP_ADD,
			fill_handles[$urandom_range(0, TEXTURE_SLOTS - 1)]), 1'b0, '0);
		offer(random_sprite(spqb_pkg::OP_ADD, stranger), 1'b0, '0);
		offer(random_sprite(spqb_pkg::OP_FLUSH, {$urandom, $urandom}), 1'b0, '0);

		// Random phases, each under its own depth setting: the most negative
		// start with a step of -1 (wraps at once), a frozen depth of zero
		// with no idling on either side, a random setting, and the reset
		// values again. Each phase waits until the core is drained.
		phase_start[0] = Q_MIN;
		phase_step[0] = -32'sd1;
		phase_start[1] = 32'sd0;
		phase_step[1] = 32'sd0;
		phase_start[2] = $urandom;
		phase_step[2] = $urandom;
		phase_start[3] = spqb_pkg::DEPTH_START_RST;
		phase_step[3] = spqb_pkg::DEPTH_STEP_RST;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			pause_until_drained();
			steady = (p == 1);
			load_depth_regs(phase_start[p], phase_step[p]);
			foreach (handle_pool[k])
				handle_pool[k] = {$urandom, $urandom};
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				op = ($urandom_range(0, 9) == 0) ? spqb_pkg::OP_FLUSH : spqb_pkg::OP_ADD;
				// Mostly a small set of textures so that lookups hit; now
				// and then a fresh one.
				if ($urandom_range(0, 3) != 0)
					handle = handle_pool[$urandom_range(0, POOL_SIZE - 1)];
				else
					handle = {$urandom, $urandom};
				offer(random_sprite(op, handle), 1'b0, '0);
			end
		end

		pause_until_drained();
		steady = 1'b0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
